[design/svp_pkg.sv]
// Shared types and constants for the smoothstep velocity profile.
`timescale 1ns / 1ps
package svp_pkg;
  localparam int KBits = 16;
  localparam logic [16:0] KOne = 17'h10000;
  // Fraction bits of time and markers; the ramp ratio does not depend on it
  localparam int FractionBits = 16;

  localparam logic [2:0] RegHoldEnd  = 3'd0;
  localparam logic [2:0] RegRiseEnd  = 3'd1;
  localparam logic [2:0] RegPeakEnd  = 3'd2;
  localparam logic [2:0] RegFallEnd  = 3'd3;
  localparam logic [2:0] RegHalfEnd  = 3'd4;
  localparam logic [2:0] RegFinalEnd = 3'd5;
  localparam logic [2:0] RegPeak     = 3'd6;

  localparam logic [2:0] SegZero   = 3'd0;
  localparam logic [2:0] SegRise   = 3'd1;
  localparam logic [2:0] SegPeak   = 3'd2;
  localparam logic [2:0] SegFall   = 3'd3;
  localparam logic [2:0] SegHalf   = 3'd4;
  localparam logic [2:0] SegFinal  = 3'd5;
  localparam logic [2:0] SegThreeQ = 3'd6;

  // Back-end unit states
  typedef enum logic [1:0] {
    BE_IDLE,
    BE_DIV,
    BE_POLY,
    BE_DONE
  } be_state_t;
endpackage

[design/svp_front.sv]
// Front end: segment search and ramp operand set-up.
`timescale 1ns / 1ps
module svp_front #(
  parameter int TW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [TW-1:0] t,
  input  logic [TW-1:0] m0, m1, m2, m3, m4, m5,
  output logic          q_valid,
  input  logic          q_ready,
  output logic [2:0]    q_seg,
  output logic [TW-1:0] q_done,
  output logic [TW-1:0] q_span,
  output logic          q_full
);
  logic [2:0]    seg;
  logic [TW-1:0] a, b;
  logic          ramp;

  // first marker at or above time
  always_comb begin
    if (t <= m0) seg = svp_pkg::SegZero;
    else if (t <= m1) seg = svp_pkg::SegRise;
    else if (t <= m2) seg = svp_pkg::SegPeak;
    else if (t <= m3) seg = svp_pkg::SegFall;
    else if (t <= m4) seg = svp_pkg::SegHalf;
    else if (t <= m5) seg = svp_pkg::SegFinal;
    else seg = svp_pkg::SegThreeQ;
    case (seg)
      svp_pkg::SegRise: begin a = m0; b = m1; ramp = 1'b1; end
      svp_pkg::SegFall: begin a = m2; b = m3; ramp = 1'b1; end
      svp_pkg::SegFinal: begin a = m4; b = m5; ramp = 1'b1; end
      default: begin a = m0; b = m1; ramp = 1'b0; end
    endcase
  end

  // output register; holds while downstream stalls
  assign in_ready = !q_valid || q_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_seg  <= seg;
      q_done <= t - a;
      q_span <= b - a;
      q_full <= !ramp || (b <= a) || (t - a >= b - a);
    end
  end
endmodule

[design/svp_fifo.sv]
// Two-entry queue between front and back ends.
`timescale 1ns / 1ps
module svp_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  logic [W-1:0] mem [2];
  logic         wp, rp;
  logic [1:0]   count;
  logic         wr_en, rd_en;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rp];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) wp <= !wp;
      if (rd_en) rp <= !rp;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end
endmodule

[design/svp_back.sv]
// Back end: restoring divide for k, Horner polynomial, speed scaling.
`timescale 1ns / 1ps
module svp_back #(
  parameter int TW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    seg,
  input  logic [TW-1:0] done,
  input  logic [TW-1:0] span,
  input  logic          full,
  input  logic [15:0]   peak,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   speed,
  output logic [2:0]    seg_out
);
  svp_pkg::be_state_t state, state_next;
  logic [TW-1:0] rem;
  logic [TW-1:0] dvs;
  logic [16:0]   quo;
  logic [4:0]    cnt;
  logic [2:0]    sg;
  logic [3:0]    pstep;
  logic signed [35:0] acc;   // Horner value / power accumulator
  logic signed [17:0] k5;
  logic signed [17:0] kk;
  logic signed [17:0] mul_b;
  logic signed [53:0] prod;
  logic signed [35:0] pdiv;
  logic [TW:0]   rem_sh;
  logic [TW+1:0] diff;
  logic [18:0]   q;
  logic [16:0]   b;
  logic [34:0]   scaled;
  logic          take;

  // one shared multiplier: k-power chain then Horner
  always_comb begin
    mul_b = (pstep == 4'd9) ? k5 : kk;
    prod = acc * mul_b;
    pdiv = (prod < 0) ? 36'(-((-prod) >>> svp_pkg::KBits))
                      : 36'(prod >>> svp_pkg::KBits);
  end

  assign rem_sh = {rem, 1'b0};
  assign diff = {1'b0, rem_sh} - {2'b0, dvs};
  assign take = in_valid && in_ready;
  assign in_ready = (state == svp_pkg::BE_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= svp_pkg::BE_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      svp_pkg::BE_IDLE: if (in_valid) begin
        state_next = full ? svp_pkg::BE_POLY : svp_pkg::BE_DIV;
      end
      svp_pkg::BE_DIV: if (cnt == 5'd0) state_next = svp_pkg::BE_POLY;
      svp_pkg::BE_POLY: if (pstep == 4'd10) state_next = svp_pkg::BE_DONE;
      svp_pkg::BE_DONE: if (!out_valid || out_ready) state_next = svp_pkg::BE_IDLE;
      default: state_next = svp_pkg::BE_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      svp_pkg::BE_IDLE: if (take) begin
        sg <= seg;
        rem <= done;
        dvs <= span;
        quo <= '0;
        cnt <= 5'd16;
        pstep <= 4'd0;
        if (full) begin
          kk <= 18'(svp_pkg::KOne);
          acc <= 36'(svp_pkg::KOne);
        end
      end
      svp_pkg::BE_DIV: begin
        // done < span, so 16 quotient bits give k in Q0.16
        if (cnt != 5'd0) begin
          if (!diff[TW+1]) begin
            rem <= diff[TW-1:0];
            quo <= {quo[15:0], 1'b1};
          end else begin
            rem <= rem_sh[TW-1:0];
            quo <= {quo[15:0], 1'b0};
          end
          cnt <= cnt - 5'd1;
        end else begin
          kk <= {1'b0, quo};
          acc <= {19'd0, quo};
        end
      end
      svp_pkg::BE_POLY: begin
        // steps 0-3: k^2..k^5, step 3 also starts h=-126; 4-8 Horner; 9: times k^5
        case (pstep)
          4'd0, 4'd1, 4'd2: acc <= pdiv;
          4'd3: begin k5 <= pdiv[17:0]; acc <= -36'sd126 <<< svp_pkg::KBits; end
          4'd4: acc <= pdiv + (36'sd700 <<< svp_pkg::KBits);
          4'd5: acc <= pdiv - (36'sd1575 <<< svp_pkg::KBits);
          4'd6: acc <= pdiv + (36'sd1800 <<< svp_pkg::KBits);
          4'd7: acc <= pdiv - (36'sd1050 <<< svp_pkg::KBits);
          4'd8: acc <= pdiv + (36'sd252 <<< svp_pkg::KBits);
          4'd9: acc <= pdiv;
          default: acc <= acc;
        endcase
        pstep <= pstep + 4'd1;
      end
      default: ;
    endcase
  end

  // level and speed scaling
  always_comb begin
    if (acc < 0) b = '0;
    else if (acc > 36'sd65536) b = svp_pkg::KOne;
    else b = acc[16:0];
    case (sg)
      svp_pkg::SegZero: q = '0;
      svp_pkg::SegRise: q = {b, 2'b00};
      svp_pkg::SegPeak: q = 19'h40000;
      svp_pkg::SegFall: q = 19'h40000 - {1'b0, b, 1'b0};
      svp_pkg::SegHalf: q = 19'h20000;
      svp_pkg::SegFinal: q = 19'h20000 + {2'b00, b};
      default: q = 19'h30000;
    endcase
    scaled = (35'(peak) * 35'(q) + 35'h20000) >> 18;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (state == svp_pkg::BE_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (state == svp_pkg::BE_DONE && (!out_valid || out_ready)) begin
      speed <= (scaled > 35'd65535) ? 16'hFFFF : scaled[15:0];
      seg_out <= sg;
    end
  end
endmodule

[design/smoothstep_velocity_profile.sv]
// Top level: registers, front end, queue, back end.
//
//  channel | signals                                        | transfer when
//  input   | in_valid, in_ready, time_s                     | in_valid & in_ready
//  output  | out_valid, out_ready, speed_rpm, segment_index | out_valid & out_ready
//  config  | cfg_we, cfg_index, cfg_data                    | cfg_we
//
// The back end takes a ramp item, runs the divider, then the shared multiplier,
// then registers the result; a hold item skips the divider. Each item passes
// the front register and the queue on its way from transfer in to result valid.
// Up to three items wait ahead of the back end; the back end stalls while its
// result is not taken. Reset restores register defaults.
`timescale 1ns / 1ps
module smoothstep_velocity_profile #(
  parameter int TIME_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_WIDTH-1:0] time_s,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           speed_rpm,
  output logic [2:0]            segment_index,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [TIME_WIDTH-1:0] cfg_data
);
  localparam int QW = 3 + 2 * TIME_WIDTH + 1;

  logic [TIME_WIDTH-1:0] m0, m1, m2, m3, m4, m5;
  logic [15:0] peak_speed;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      m0 <= TIME_WIDTH'(79438);
      m1 <= TIME_WIDTH'(397188);
      m2 <= TIME_WIDTH'(1191564);
      m3 <= TIME_WIDTH'(1747627);
      m4 <= TIME_WIDTH'(2541991);
      m5 <= TIME_WIDTH'(2621440);
      peak_speed <= 16'd14668;
    end else if (cfg_we) begin
      case (cfg_index)
        svp_pkg::RegHoldEnd:  m0 <= cfg_data;
        svp_pkg::RegRiseEnd:  m1 <= cfg_data;
        svp_pkg::RegPeakEnd:  m2 <= cfg_data;
        svp_pkg::RegFallEnd:  m3 <= cfg_data;
        svp_pkg::RegHalfEnd:  m4 <= cfg_data;
        svp_pkg::RegFinalEnd: m5 <= cfg_data;
        svp_pkg::RegPeak:     peak_speed <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic f_valid, f_ready, f_full;
  logic [2:0] f_seg;
  logic [TIME_WIDTH-1:0] f_done, f_span;

  svp_front #(.TW(TIME_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .t(time_s),
    .m0, .m1, .m2, .m3, .m4, .m5,
    .q_valid(f_valid), .q_ready(f_ready), .q_seg(f_seg),
    .q_done(f_done), .q_span(f_span), .q_full(f_full)
  );

  logic b_valid, b_ready;
  logic [QW-1:0] b_data;

  svp_fifo #(.W(QW)) u_fifo (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data({f_seg, f_done, f_span, f_full}),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  svp_back #(.TW(TIME_WIDTH)) u_back (
    .clk, .rst,
    .in_valid(b_valid), .in_ready(b_ready),
    .seg(b_data[QW-1 -: 3]),
    .done(b_data[2*TIME_WIDTH -: TIME_WIDTH]),
    .span(b_data[TIME_WIDTH:1]),
    .full(b_data[0]),
    .peak(peak_speed),
    .out_valid, .out_ready,
    .speed(speed_rpm), .seg_out(segment_index)
  );
endmodule
